// ----- src/pcar_pkg.sv -----
// ----------------------------------------------------------------------------
// pcar_pkg
// Shared types, codes and helpers of the blockwise PCA reconstruct unit.
// ----------------------------------------------------------------------------
package pcar_pkg;

   // request operation codes (req_tuser)
   localparam logic [1:0] OP_MEAN   = 2'd0;
   localparam logic [1:0] OP_WEIGHT = 2'd1;
   localparam logic [1:0] OP_SAMPLE = 2'd2;

   localparam int ACC_W  = 40;
   localparam int PROD_W = 56;
   localparam int SUM_W  = 64;
   localparam int FRAC_SHIFT = 30;

   typedef enum logic [1:0] {
      TK_WEIGHT,
      TK_SAMPLE,
      TK_RECON
   } pcar_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAIN,
      ST_RECON
   } pcar_state_type;

   // token that walks down the cell chain
   typedef struct packed {
      logic          valid;
      pcar_kind_type kind;
      logic          elem_ok;
      logic          last_out;
      logic [3:0]    nk;
      logic [2:0]    comp;
      logic [7:0]    blk;
      logic [5:0]    elem;
      logic [15:0]   data;
      logic [16:0]   cent;
   } pcar_tok_type;

   // block_index modulo n, restoring long division by a constant
   function automatic logic [12:0] pcar_mod_blocks(input logic [7:0] blk,
                                                   input int unsigned n);
      logic [13:0] r;
      r = '0;
      for (int i = 7; i >= 0; i--) begin
         r = {r[12:0], blk[i]};
         if (32'(r) >= n) begin
            r = 14'(32'(r) - n);
         end
      end
      return r[12:0];
   endfunction

endpackage

// ----- src/pcar_ram.sv -----
// ----------------------------------------------------------------------------
// pcar_ram
// Single-port RAM, one address shared by write and registered read.
// ----------------------------------------------------------------------------
module pcar_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/pcar_cell.sv -----
// ----------------------------------------------------------------------------
// pcar_cell
// One principal component: weight RAM, projection accumulator and one
// multiplier. Tokens move one cell per cycle while the chain advances; the
// reconstruction sum trails its token, leaving with sum_tok after the a, b and s registers.
// ----------------------------------------------------------------------------
module pcar_cell #(
   parameter int INDEX = 0,
   parameter int DEPTH = 12288,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  pcar_pkg::pcar_tok_type           tok_in,
   input  logic [AW-1:0]                    addr_in,
   input  logic signed [pcar_pkg::SUM_W-1:0] sum_in,
   output pcar_pkg::pcar_tok_type           tok_out,
   output logic [AW-1:0]                    addr_out,
   output logic signed [pcar_pkg::SUM_W-1:0] sum_out,
   output pcar_pkg::pcar_tok_type           sum_tok
);

   pcar_pkg::pcar_tok_type a_ff, b_ff, s_ff;
   logic [AW-1:0]          addr_ff;
   logic [15:0]            w_rd;
   logic                   w_we;

   logic signed [pcar_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic signed [pcar_pkg::ACC_W-1:0]  mul_a;
   logic signed [pcar_pkg::PROD_W-1:0] prod;
   logic signed [pcar_pkg::PROD_W-1:0] prod_ff;
   logic                               use_a, use_ff;
   logic signed [pcar_pkg::ACC_W:0]    acc_sum;
   logic signed [pcar_pkg::SUM_W-1:0]  sum_ff, sum_in_nx;

   assign w_we = advance && tok_in.valid && (tok_in.kind == pcar_pkg::TK_WEIGHT) &&
                 tok_in.elem_ok && (32'(tok_in.comp) == INDEX);

   pcar_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_weight_ram (
      .clock (clock),
      .en    (advance),
      .we    (w_we),
      .addr  (addr_in),
      .wdata (tok_in.data),
      .rdata (w_rd)
   );

   // stage A: weight read data lines up with the token
   assign use_a = a_ff.valid && a_ff.elem_ok && (INDEX < 32'(a_ff.nk)) &&
                  (a_ff.kind != pcar_pkg::TK_WEIGHT);
   assign mul_a = (a_ff.kind == pcar_pkg::TK_RECON) ? acc_ff :
                  {{(pcar_pkg::ACC_W-17){a_ff.cent[16]}}, a_ff.cent};
   assign prod  = mul_a * $signed(w_rd);

   // stage B: accumulate (saturating) or add into the running sum
   assign acc_sum = {acc_ff[pcar_pkg::ACC_W-1], acc_ff} +
                    {{(pcar_pkg::ACC_W-32){prod_ff[32]}}, prod_ff[32:0]};

   always_comb begin
      acc_in = acc_ff;
      if (b_ff.valid && (b_ff.kind == pcar_pkg::TK_SAMPLE) && use_ff) begin
         if (acc_sum[pcar_pkg::ACC_W] != acc_sum[pcar_pkg::ACC_W-1]) begin
            acc_in = acc_sum[pcar_pkg::ACC_W] ?
                     {1'b1, {(pcar_pkg::ACC_W-1){1'b0}}} :
                     {1'b0, {(pcar_pkg::ACC_W-1){1'b1}}};
         end else begin
            acc_in = acc_sum[pcar_pkg::ACC_W-1:0];
         end
      end else if (b_ff.valid && (b_ff.kind == pcar_pkg::TK_RECON) && b_ff.last_out) begin
         acc_in = '0;
      end
   end

   always_comb begin
      sum_in_nx = sum_in;
      if (b_ff.valid && (b_ff.kind == pcar_pkg::TK_RECON) && use_ff) begin
         sum_in_nx = sum_in + {{(pcar_pkg::SUM_W-pcar_pkg::PROD_W){prod_ff[pcar_pkg::PROD_W-1]}},
                               prod_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff   <= '0;
         b_ff   <= '0;
         s_ff   <= '0;
         acc_ff <= '0;
      end else if (advance) begin
         a_ff   <= tok_in;
         b_ff   <= a_ff;
         s_ff   <= b_ff;
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         addr_ff <= addr_in;
         prod_ff <= prod;
         use_ff  <= use_a;
         sum_ff  <= sum_in_nx;
      end
   end

   assign tok_out  = a_ff;
   assign addr_out = addr_ff;
   assign sum_out  = sum_ff;
   assign sum_tok  = s_ff;

endmodule

// ----- src/blockwise_pca_reconstruct_unit.sv -----
// ----------------------------------------------------------------------------
// blockwise_pca_reconstruct_unit
// Projects image block samples onto stored principal components and emits
// the reconstructed block.
// ----------------------------------------------------------------------------
// Loads and samples are taken one per cycle while the sequencer is idle and
// the output is not stalled, and run through a chain of MAX_COMPONENTS cells,
// one per component, each with its own weight RAM and accumulator. A sample
// flagged tlast closes the input while the sequencer passes a drain state and
// then issues one reconstruction token per element; the input then reopens. A
// stalled result freezes the whole chain, including the input. Mean and weight
// tables (NUM_BLOCKS*BLOCK_ELEMENTS words per RAM) are not cleared by reset and
// must be loaded before use.
// ----------------------------------------------------------------------------
module blockwise_pca_reconstruct_unit #(
   parameter int BLOCK_ELEMENTS = 48,
   parameter int MAX_COMPONENTS = 8,
   parameter int NUM_BLOCKS     = 256
) (
   input  logic        clock,
   input  logic        reset,
   // block_index[7:0], component_index[10:8], element_index[16:11],
   // data_value[32:17], zero [39:33]
   input  logic [39:0] req_tdata,
   input  logic [1:0]  req_tuser,   // operation[1:0]
   input  logic        req_tlast,   // last_element
   input  logic        req_tvalid,
   output logic        req_tready,
   // pixel_value[15:0], out_element[21:16], out_block[29:22], zero [31:30]
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast,   // end_of_block
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_we,
   input  logic [3:0]  csr_wdata    // active_components
);

   localparam int DEPTH = NUM_BLOCKS * BLOCK_ELEMENTS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = (BLOCK_ELEMENTS > 1) ? $clog2(BLOCK_ELEMENTS) : 1;
   localparam int K     = MAX_COMPONENTS;

   pcar_pkg::pcar_state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [7:0]    blk_ff, blk_in;
   logic [3:0]    nk_ff;

   logic        advance, accept;
   logic [7:0]  in_blk;
   logic [2:0]  in_comp;
   logic [5:0]  in_elem;
   logic [15:0] in_data;
   logic        in_elem_ok;

   pcar_pkg::pcar_tok_type d_tok, f1_ff, c0_tok;
   logic [12:0]   blk_mod;
   logic [5:0]    elem_sel;
   logic [31:0]   addr_wide;
   logic [AW-1:0] d_addr, f1_addr_ff;
   logic          mean_we;
   logic [15:0]   mean_rd;

   logic signed [pcar_pkg::SUM_W-1:0] s1_ff, s2_ff;

   pcar_pkg::pcar_tok_type            tok_c  [K];
   pcar_pkg::pcar_tok_type            stok_c [K];
   logic [AW-1:0]                     addr_c [K];
   logic signed [pcar_pkg::SUM_W-1:0] sum_c  [K];

   logic signed [pcar_pkg::SUM_W-1:0] rnd;
   logic signed [33:0]                rnd_hi;
   logic [15:0]                       pix;
   logic                              rsp_valid_ff;
   logic [31:0]                       rsp_data_ff;
   logic                              rsp_last_ff;

   assign advance = !rsp_valid_ff || rsp_tready;
   assign accept  = req_tvalid && req_tready;

   assign in_blk     = req_tdata[7:0];
   assign in_comp    = req_tdata[10:8];
   assign in_elem    = req_tdata[16:11];
   assign in_data    = req_tdata[32:17];
   assign in_elem_ok = 32'(in_elem) < BLOCK_ELEMENTS;

   // ---------------- sequencer ----------------
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      blk_in     = blk_ff;
      req_tready = 1'b0;
      case (state_ff)
         pcar_pkg::ST_IDLE: begin
            req_tready = advance;
            if (accept && (req_tuser == pcar_pkg::OP_SAMPLE) && req_tlast) begin
               state_in = pcar_pkg::ST_DRAIN;
               blk_in   = in_blk;
            end
         end
         pcar_pkg::ST_DRAIN: begin
            if (advance) begin
               state_in = pcar_pkg::ST_RECON;
               cnt_in   = '0;
            end
         end
         pcar_pkg::ST_RECON: begin
            if (advance) begin
               if (cnt_ff == CW'(BLOCK_ELEMENTS - 1)) begin
                  state_in = pcar_pkg::ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = pcar_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcar_pkg::ST_IDLE;
         nk_ff    <= 4'd8;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            nk_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      blk_ff <= blk_in;
   end

   // ---------------- dispatch ----------------
   always_comb begin
      d_tok         = '0;
      d_tok.nk      = nk_ff;
      d_tok.blk     = in_blk;
      d_tok.comp    = in_comp;
      d_tok.elem    = in_elem;
      d_tok.data    = in_data;
      d_tok.elem_ok = in_elem_ok;
      d_tok.kind    = pcar_pkg::TK_SAMPLE;
      if (state_ff == pcar_pkg::ST_RECON) begin
         d_tok.valid    = 1'b1;
         d_tok.kind     = pcar_pkg::TK_RECON;
         d_tok.blk      = blk_ff;
         d_tok.elem     = 6'(cnt_ff);
         d_tok.elem_ok  = 1'b1;
         d_tok.last_out = (cnt_ff == CW'(BLOCK_ELEMENTS - 1));
      end else if (accept) begin
         case (req_tuser)
            pcar_pkg::OP_WEIGHT: begin
               d_tok.valid = 1'b1;
               d_tok.kind  = pcar_pkg::TK_WEIGHT;
            end
            pcar_pkg::OP_SAMPLE: begin
               d_tok.valid = 1'b1;
               d_tok.kind  = pcar_pkg::TK_SAMPLE;
            end
            default: begin
               d_tok.valid = 1'b0;
            end
         endcase
      end
   end

   assign blk_mod   = pcar_pkg::pcar_mod_blocks(d_tok.blk, NUM_BLOCKS);
   assign elem_sel  = d_tok.elem_ok ? d_tok.elem : 6'd0;
   assign addr_wide = 32'(blk_mod) * BLOCK_ELEMENTS + 32'(elem_sel);
   assign d_addr    = addr_wide[AW-1:0];
   assign mean_we   = accept && (req_tuser == pcar_pkg::OP_MEAN) && in_elem_ok;

   pcar_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_mean_ram (
      .clock (clock),
      .en    (advance),
      .we    (mean_we),
      .addr  (d_addr),
      .wdata (in_data),
      .rdata (mean_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_ff <= '0;
      end else if (advance) begin
         f1_ff <= d_tok;
      end
   end

   // mean << 30 is delayed to meet cell 0's sum input
   always_ff @(posedge clock) begin
      if (advance) begin
         f1_addr_ff <= d_addr;
         s1_ff      <= {{(pcar_pkg::SUM_W-16-pcar_pkg::FRAC_SHIFT){mean_rd[15]}}, mean_rd,
                        {pcar_pkg::FRAC_SHIFT{1'b0}}};
         s2_ff      <= s1_ff;
      end
   end

   always_comb begin
      c0_tok      = f1_ff;
      c0_tok.cent = {f1_ff.data[15], f1_ff.data} - {mean_rd[15], mean_rd};
   end

   // ---------------- cell chain ----------------
   for (genvar k = 0; k < K; k++) begin : g_cell
      if (k == 0) begin : g_head
         pcar_cell #(.INDEX(k), .DEPTH(DEPTH)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .advance  (advance),
            .tok_in   (c0_tok),
            .addr_in  (f1_addr_ff),
            .sum_in   (s2_ff),
            .tok_out  (tok_c[k]),
            .addr_out (addr_c[k]),
            .sum_out  (sum_c[k]),
            .sum_tok  (stok_c[k])
         );
      end else begin : g_body
         pcar_cell #(.INDEX(k), .DEPTH(DEPTH)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .advance  (advance),
            .tok_in   (tok_c[k-1]),
            .addr_in  (addr_c[k-1]),
            .sum_in   (sum_c[k-1]),
            .tok_out  (tok_c[k]),
            .addr_out (addr_c[k]),
            .sum_out  (sum_c[k]),
            .sum_tok  (stok_c[k])
         );
      end
   end

   // ---------------- round, saturate, output register ----------------
   assign rnd    = (sum_c[K-1] + (64'sd1 <<< (pcar_pkg::FRAC_SHIFT - 1))) >>>
                   pcar_pkg::FRAC_SHIFT;
   assign rnd_hi = rnd[33:0];

   always_comb begin
      if (rnd_hi > 34'sd32767) begin
         pix = 16'h7FFF;
      end else if (rnd_hi < -34'sd32768) begin
         pix = 16'h8000;
      end else begin
         pix = rnd_hi[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= stok_c[K-1].valid && (stok_c[K-1].kind == pcar_pkg::TK_RECON);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {2'b00, stok_c[K-1].blk, stok_c[K-1].elem, pix};
         rsp_last_ff <= stok_c[K-1].last_out;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- src/pcar_checker.sv -----
// ----------------------------------------------------------------------------
// pcar_checker
// Port-level checks of the blockwise PCA reconstruct unit.
// ----------------------------------------------------------------------------
module pcar_checker #(
   parameter int BLOCK_ELEMENTS = 48
) (
   input logic        clock,
   input logic        reset,
   input logic [39:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        req_tlast,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic        csr_we,
   input logic [3:0]  csr_wdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp changed while stalled");

   // a stalled output freezes the input side too
   a_stall_in: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("req taken while rsp stalled");

   // input closes while a block is being rebuilt
   a_last_close: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast && (req_tuser == pcar_pkg::OP_SAMPLE)
      |=> !req_tready)
      else $error("req open right after last sample");

   // end of block only on the final element
   a_eob_elem: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[21:16] == 6'(BLOCK_ELEMENTS - 1))
      else $error("end of block on wrong element");

endmodule

bind blockwise_pca_reconstruct_unit pcar_checker #(
   .BLOCK_ELEMENTS(BLOCK_ELEMENTS)
) u_pcar_checker (.*);
